@@ rtl/core/ofdm_rx_preamble_sequencer_assert.svh @@
// Assertion macros used by the sequencer checker.
`ifndef OFDM_RX_PREAMBLE_SEQUENCER_ASSERT_SVH
`define OFDM_RX_PREAMBLE_SEQUENCER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define OFDMPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ofdmps assertion failed");

// Condition must never be true outside reset.
`define OFDMPS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("ofdmps forbidden condition seen");

`endif

@@ rtl/core/ofdmps_pkg.sv @@
// Package: types and codes of the OFDM receive preamble sequencer.
package ofdmps_pkg;

  localparam int unsigned CounterWidthDefault = 16;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 16;

  typedef enum logic [2:0] {
    STAGE_DETECT = 3'd0,
    STAGE_AGC    = 3'd1,
    STAGE_NOISE  = 3'd2,
    STAGE_FREQ   = 3'd3,
    STAGE_LFM    = 3'd4,
    STAGE_QAM4   = 3'd5,
    STAGE_IDLE   = 3'd6,
    STAGE_HALT   = 3'd7
  } stage_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_PILOT_TIMEOUT = 3'd0,
    CFG_MUTE_START    = 3'd1,
    CFG_MUTE_STOP     = 3'd2,
    CFG_LFM_WAIT      = 3'd3,
    CFG_QAM4_WAIT     = 3'd4,
    CFG_START_TYPE    = 3'd5
  } cfg_idx_e;

  // Negotiation substate codes
  localparam logic [1:0] NEGO_TYPE1 = 2'd0;
  localparam logic [1:0] NEGO_TYPE2 = 2'd1;

  // Pilot detect codes
  localparam logic [1:0] PILOT_NONE  = 2'd0;
  localparam logic [1:0] PILOT_TYPE1 = 2'd1;
  localparam logic [1:0] PILOT_TYPE2 = 2'd2;

  // Sync status codes
  localparam logic [2:0] SYNC_DETECT     = 3'd0;
  localparam logic [2:0] SYNC_TONE_SRCH  = 3'd1;
  localparam logic [2:0] SYNC_TONE_FOUND = 3'd2;
  localparam logic [2:0] SYNC_NOISE_DONE = 3'd3;
  localparam logic [2:0] SYNC_FREQ_DONE  = 3'd4;
  localparam logic [2:0] SYNC_LFM_DONE   = 3'd5;
  localparam logic [2:0] SYNC_QAM4_FOUND = 3'd6;

  // Error flag bits
  localparam int unsigned ErrMuteStart = 0;
  localparam int unsigned ErrMuteStop  = 1;
  localparam int unsigned ErrLfmWait   = 2;
  localparam int unsigned ErrQam4Wait  = 3;
  localparam int unsigned ErrModeOff   = 4;

  typedef struct packed {
    logic        mode;
    logic [1:0]  pilot_detect;
    logic        stage_finished;
    logic [15:0] noise_start_count;
    logic [15:0] noise_stop_count;
    logic [15:0] lfm_wait_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] preamble_stage;
    logic [1:0] negotiation_state;
    logic [2:0] sync_status;
    logic       start_two_tone;
    logic       nl_call;
    logic       restart_request;
    logic       emergency_restart;
    logic       start_data;
    logic [4:0] error_flags;
    logic [7:0] error_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pilot_timeout;
    logic [15:0] mute_start_limit;
    logic [15:0] mute_stop_limit;
    logic [15:0] lfm_wait_limit;
    logic [15:0] qam4_wait_limit;
    logic [1:0]  start_type;
  } cfg_t;

endpackage

@@ rtl/core/ofdm_rx_preamble_sequencer.sv @@
// Top level of the OFDM receive preamble sequencer.
//
// Requests arrive on in_req_i under in_valid_i / in_stall_o; one request is
// either a start (mode 1: detection mode, substate from start_type, wait
// counters cleared) or a tick carrying pilot result, stage-finished flag and
// the external wait counts. Every request yields exactly one result on
// out_rsp_o under out_valid_o / out_stall_i.
// Registers are written through cfg_valid_i / cfg_index_i / cfg_data_i;
// cfg_ready_o is always high. The user must let writes go in only while no
// request is in flight; the block does not enforce it. Throughput: one
// request per cycle unless out_stall_i holds; the state update of one request
// is a single pass from the input register to the result register.
// Reset clears both valid flags, all state and loads register defaults.
// A stall on the result side holds the result register; the input register
// still takes one more request, and in_stall_o rises only when both are full.
module ofdm_rx_preamble_sequencer
  import ofdmps_pkg::*;
#(
  parameter int unsigned CounterWidth = CounterWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_rsp_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_req_q;
  out_item_t rsp, out_rsp_q;
  logic      in_valid_q, in_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      advance, in_accept;

  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  assign cfg_ready_o = 1'b1;

  ofdmps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ofdmps_fsm #(
    .CounterWidth (CounterWidth)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ rtl/core/ofdmps_cfg.sv @@
// Configuration register file of the preamble sequencer.
module ofdmps_cfg
  import ofdmps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PILOT_TIMEOUT: cfg_d.pilot_timeout    = cfg_data_i;
        CFG_MUTE_START:    cfg_d.mute_start_limit = cfg_data_i;
        CFG_MUTE_STOP:     cfg_d.mute_stop_limit  = cfg_data_i;
        CFG_LFM_WAIT:      cfg_d.lfm_wait_limit   = cfg_data_i;
        CFG_QAM4_WAIT:     cfg_d.qam4_wait_limit  = cfg_data_i;
        CFG_START_TYPE:    cfg_d.start_type       = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pilot_timeout    <= 16'd100;
      cfg_q.mute_start_limit <= 16'd100;
      cfg_q.mute_stop_limit  <= 16'd100;
      cfg_q.lfm_wait_limit   <= 16'd100;
      cfg_q.qam4_wait_limit  <= 16'd100;
      cfg_q.start_type       <= NEGO_TYPE1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/ofdmps_fsm.sv @@
// Stage state machine, wait counters and error total of the sequencer.
module ofdmps_fsm
  import ofdmps_pkg::*;
#(
  parameter int unsigned CounterWidth = CounterWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  req_i,
  input  cfg_t      cfg_i,
  output out_item_t rsp_o
);

  localparam int unsigned CmpWidth = (CounterWidth > 16) ? CounterWidth : 16;
  localparam logic [CounterWidth-1:0] CtrMax = {CounterWidth{1'b1}};

  stage_e                  stage_q, stage_d;
  logic [1:0]              nego_q, nego_d;
  logic [2:0]              sync_q, sync_d;
  logic [CounterWidth-1:0] pilot_cnt_q, pilot_cnt_d;
  logic [CounterWidth-1:0] qam4_cnt_q, qam4_cnt_d;
  logic [7:0]              err_total_q, err_total_d;

  logic [CounterWidth-1:0] pilot_inc, qam4_inc;
  logic                    pilot_expired, qam4_expired;
  logic [1:0]              err_add;
  logic [8:0]              err_sum;
  logic [4:0]              flags;
  logic                    two_tone, nl, restart, emerg, sdata;

  assign pilot_inc = (pilot_cnt_q == CtrMax) ? CtrMax : pilot_cnt_q + 1'b1;
  assign qam4_inc  = (qam4_cnt_q == CtrMax) ? CtrMax : qam4_cnt_q + 1'b1;
  assign pilot_expired = CmpWidth'(pilot_cnt_q) > CmpWidth'(cfg_i.pilot_timeout);
  assign qam4_expired  = CmpWidth'(qam4_cnt_q) > CmpWidth'(cfg_i.qam4_wait_limit);

  always_comb begin
    stage_d     = stage_q;
    nego_d      = nego_q;
    sync_d      = sync_q;
    pilot_cnt_d = pilot_cnt_q;
    qam4_cnt_d  = qam4_cnt_q;
    flags       = '0;
    two_tone    = 1'b0;
    nl          = 1'b0;
    restart     = 1'b0;
    emerg       = 1'b0;
    sdata       = 1'b0;
    if (req_i.mode) begin
      stage_d     = STAGE_DETECT;
      nego_d      = cfg_i.start_type;
      sync_d      = SYNC_DETECT;
      pilot_cnt_d = '0;
      qam4_cnt_d  = '0;
    end else begin
      case (stage_q)
        STAGE_DETECT: begin
          sync_d = SYNC_DETECT;
          if (nego_q == NEGO_TYPE1) begin
            if (req_i.pilot_detect == PILOT_TYPE1) begin
              stage_d     = STAGE_AGC;
              two_tone    = 1'b1;
              pilot_cnt_d = '0;
            end else if (req_i.pilot_detect == PILOT_TYPE2) begin
              nl = 1'b1;
            end
          end else if (nego_q == NEGO_TYPE2) begin
            if (req_i.pilot_detect == PILOT_TYPE1) begin
              nego_d      = NEGO_TYPE1;
              pilot_cnt_d = '0;
              restart     = 1'b1;
            end else if (req_i.pilot_detect == PILOT_TYPE2) begin
              stage_d     = STAGE_AGC;
              two_tone    = 1'b1;
              pilot_cnt_d = '0;
            end else if (req_i.pilot_detect == PILOT_NONE) begin
              if (pilot_expired) begin
                nego_d      = NEGO_TYPE1;
                pilot_cnt_d = '0;
                restart     = 1'b1;
              end else begin
                pilot_cnt_d = pilot_inc;
              end
            end
          end else begin
            flags[ErrModeOff] = 1'b1;
            stage_d           = STAGE_HALT;
          end
        end
        STAGE_AGC: begin
          sync_d = SYNC_TONE_SRCH;
          if (req_i.stage_finished) begin
            stage_d = STAGE_NOISE;
            sync_d  = SYNC_TONE_FOUND;
          end
        end
        STAGE_NOISE: begin
          if (req_i.stage_finished) begin
            stage_d = STAGE_FREQ;
            sync_d  = SYNC_NOISE_DONE;
          end else begin
            flags[ErrMuteStart] = req_i.noise_start_count > cfg_i.mute_start_limit;
            flags[ErrMuteStop]  = req_i.noise_stop_count > cfg_i.mute_stop_limit;
          end
        end
        STAGE_FREQ: begin
          if (req_i.stage_finished) begin
            stage_d = STAGE_LFM;
            sync_d  = SYNC_FREQ_DONE;
          end
        end
        STAGE_LFM: begin
          if (req_i.stage_finished) begin
            stage_d = STAGE_QAM4;
            sync_d  = SYNC_LFM_DONE;
          end else if (req_i.lfm_wait_count > cfg_i.lfm_wait_limit) begin
            flags[ErrLfmWait] = 1'b1;
            emerg             = 1'b1;
          end
        end
        STAGE_QAM4: begin
          if (req_i.stage_finished) begin
            stage_d    = STAGE_IDLE;
            sync_d     = SYNC_QAM4_FOUND;
            qam4_cnt_d = '0;
            sdata      = 1'b1;
          end else begin
            flags[ErrQam4Wait] = qam4_expired;
            qam4_cnt_d         = qam4_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // At most two errors in one tick (mute start and mute stop)
  assign err_add     = 2'($countones(flags));
  assign err_sum     = {1'b0, err_total_q} + {7'd0, err_add};
  assign err_total_d = err_sum[8] ? 8'hFF : err_sum[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STAGE_DETECT;
      nego_q      <= NEGO_TYPE1;
      sync_q      <= SYNC_DETECT;
      pilot_cnt_q <= '0;
      qam4_cnt_q  <= '0;
      err_total_q <= '0;
    end else if (step_i) begin
      stage_q     <= stage_d;
      nego_q      <= nego_d;
      sync_q      <= sync_d;
      pilot_cnt_q <= pilot_cnt_d;
      qam4_cnt_q  <= qam4_cnt_d;
      err_total_q <= err_total_d;
    end
  end

  always_comb begin
    rsp_o.preamble_stage    = stage_d;
    rsp_o.negotiation_state = nego_d;
    rsp_o.sync_status       = sync_d;
    rsp_o.start_two_tone    = two_tone;
    rsp_o.nl_call           = nl;
    rsp_o.restart_request   = restart;
    rsp_o.emergency_restart = emerg;
    rsp_o.start_data        = sdata;
    rsp_o.error_flags       = flags;
    rsp_o.error_count       = err_total_d;
  end

endmodule

@@ rtl/core/ofdmps_checker.sv @@
// Port-level checker of the preamble sequencer, bound to the top level.
`include "ofdm_rx_preamble_sequencer_assert.svh"

module ofdmps_checker
  import ofdmps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_rsp_o
);

  logic       acc;
  logic       flagged;
  logic [7:0] cnt;
  logic [4:0] pulses;

  assign acc     = out_valid_o && !out_stall_i;
  assign flagged = |out_rsp_o.error_flags;
  assign cnt     = out_rsp_o.error_count;
  assign pulses  = {out_rsp_o.start_two_tone, out_rsp_o.nl_call, out_rsp_o.restart_request,
                    out_rsp_o.emergency_restart, out_rsp_o.start_data};

  `OFDMPS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)

  `OFDMPS_ASSERT(a_err_count_mono, clk_i, rst_ni, (acc && $past(acc)) |-> (cnt >= $past(cnt)))

  `OFDMPS_ASSERT(a_one_pulse, clk_i, rst_ni, out_valid_o |-> $onehot0(pulses))

  `OFDMPS_ASSERT_NEVER(a_flag_no_count, clk_i, rst_ni, out_valid_o && flagged && (cnt == 8'd0))

endmodule

bind ofdm_rx_preamble_sequencer ofdmps_checker u_ofdmps_checker (.*);
